// File: rtl/core/swpd_pkg.sv
`default_nettype none

package swpd_pkg;

  localparam int IndexWidth = 5;
  localparam int ByteWidth  = 8;
  localparam int WordWidth  = 16;
  localparam int WordsWidth = 5;
  localparam int KindWidth  = 2;
  localparam int CfgIdxWidth = 3;

  // Six timestamp bytes, then the two millisecond bytes
  localparam int TsByteFields  = 6;
  localparam int MsFields      = 2;
  localparam int LastOffset    = TsByteFields + MsFields - 1;
  localparam int WordFieldsMin = 1;
  localparam int WordFieldsMax = 24;

  localparam logic [ByteWidth-1:0]  SyncKind0Reset  = 8'hAA;
  localparam logic [ByteWidth-1:0]  SyncKind1Reset  = 8'hBB;
  localparam logic [ByteWidth-1:0]  SyncKind2Reset  = 8'hCC;
  localparam logic [WordsWidth-1:0] WordsKind0Reset = 5'd5;
  localparam logic [WordsWidth-1:0] WordsKind1Reset = 5'd3;
  localparam logic [WordsWidth-1:0] WordsKind2Reset = 5'd19;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SYNC_KIND0  = 3'd0,
    CFG_SYNC_KIND1  = 3'd1,
    CFG_SYNC_KIND2  = 3'd2,
    CFG_WORDS_KIND0 = 3'd3,
    CFG_WORDS_KIND1 = 3'd4,
    CFG_WORDS_KIND2 = 3'd5
  } cfg_reg_t;

  typedef enum logic [KindWidth-1:0] {
    KIND0 = 2'd0,
    KIND1 = 2'd1,
    KIND2 = 2'd2
  } kind_t;

  typedef struct packed {
    logic [KindWidth-1:0]  packet_kind;
    logic [IndexWidth-1:0] field_index;
    logic [WordWidth-1:0]  field_value;
    logic                  field_is_byte;
    logic                  packet_done;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/sync_word_packet_deframer_unit.sv
// An accepted byte's result is registered in the output or skid register.
// Throughput: one byte per cycle while in_ready is high; all framing logic
// sits between the byte input and a two-entry result buffer (output register
// plus skid register). in_ready drops only while the skid register is full.
// Reset (rst, synchronous): sync bytes and word counts return to their
// defaults, no packet is active and the result buffer is emptied.
`default_nettype none

module sync_word_packet_deframer_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [swpd_pkg::ByteWidth-1:0]       rx_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [swpd_pkg::KindWidth-1:0]            packet_kind,
  output logic [swpd_pkg::IndexWidth-1:0]           field_index,
  output logic [swpd_pkg::WordWidth-1:0]            field_value,
  output logic                                      field_is_byte,
  output logic                                      packet_done,
  input  wire logic                                 cfg_we,
  input  wire logic [swpd_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  wire logic [swpd_pkg::ByteWidth-1:0]       cfg_data
);

  localparam int CmpWidth = swpd_pkg::IndexWidth + 1;

  // Configuration
  logic [swpd_pkg::ByteWidth-1:0]  sync_kind0, sync_kind1, sync_kind2;
  logic [swpd_pkg::WordsWidth-1:0] words_kind0, words_kind1, words_kind2;

  // Framing state
  logic [swpd_pkg::ByteWidth-1:0]  previous_byte;
  logic [swpd_pkg::KindWidth-1:0]  active_kind;
  logic                            kind_valid;
  logic [swpd_pkg::IndexWidth-1:0] field_counter;
  logic                            take_next;

  // Result buffer
  swpd_pkg::result_t out_reg, skid_reg;
  logic              skid_valid;

  logic                            accept;
  logic                            sync_hit;
  logic [swpd_pkg::KindWidth-1:0]  kind_eff;
  logic                            valid_eff;
  logic [swpd_pkg::IndexWidth-1:0] count_eff;
  logic                            take_eff;
  logic [swpd_pkg::WordsWidth-1:0] words_raw, words;
  logic [CmpWidth-1:0]             idx, w6, last;
  logic                            beyond, ts_byte, ms_high, done;
  logic                            emit;
  logic [swpd_pkg::KindWidth-1:0]  active_kind_next;
  logic                            kind_valid_next;
  logic [swpd_pkg::IndexWidth-1:0] field_counter_next;
  logic                            take_next_next;
  swpd_pkg::result_t               result;
  logic                            pop;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;

  // Sync detection with kind 0 taking priority
  always_comb begin
    sync_hit = 1'b0;
    kind_eff = active_kind;
    if (previous_byte == rx_byte) begin
      if (rx_byte == sync_kind0) begin
        sync_hit = 1'b1;
        kind_eff = swpd_pkg::KIND0;
      end else if (rx_byte == sync_kind1) begin
        sync_hit = 1'b1;
        kind_eff = swpd_pkg::KIND1;
      end else if (rx_byte == sync_kind2) begin
        sync_hit = 1'b1;
        kind_eff = swpd_pkg::KIND2;
      end
    end
  end

  assign valid_eff = kind_valid || sync_hit;
  assign count_eff = sync_hit ? '0 : field_counter;
  assign take_eff  = sync_hit || take_next;

  always_comb begin
    case (kind_eff)
      swpd_pkg::KIND0: words_raw = words_kind0;
      swpd_pkg::KIND1: words_raw = words_kind1;
      default:         words_raw = words_kind2;
    endcase
    // Clamp the word count to its legal range
    if (words_raw < swpd_pkg::WordsWidth'(swpd_pkg::WordFieldsMin)) begin
      words = swpd_pkg::WordsWidth'(swpd_pkg::WordFieldsMin);
    end else if (words_raw > swpd_pkg::WordsWidth'(swpd_pkg::WordFieldsMax)) begin
      words = swpd_pkg::WordsWidth'(swpd_pkg::WordFieldsMax);
    end else begin
      words = words_raw;
    end
  end

  assign idx     = {1'b0, count_eff};
  assign w6      = CmpWidth'(words);
  assign last    = w6 + CmpWidth'(swpd_pkg::LastOffset);
  assign beyond  = idx > last;
  assign ts_byte = (idx >= w6) && (idx < w6 + CmpWidth'(swpd_pkg::TsByteFields));
  assign ms_high = idx == last - CmpWidth'(1);
  assign done    = idx == last;

  always_comb begin
    active_kind_next   = kind_eff;
    kind_valid_next    = valid_eff;
    field_counter_next = count_eff;
    take_next_next     = take_eff;
    emit               = 1'b0;
    if (valid_eff) begin
      if (take_eff) begin
        if (beyond) begin
          // Counter ran past a shrunk packet: restart at field 0
          field_counter_next = '0;
          take_next_next     = 1'b1;
        end else begin
          emit               = !ms_high;
          take_next_next     = ((idx + CmpWidth'(1)) >= w6) && !done;
          field_counter_next = done ? '0 : count_eff + swpd_pkg::IndexWidth'(1);
        end
      end else begin
        take_next_next = 1'b1;
      end
    end
  end

  always_comb begin
    result.packet_kind   = kind_eff;
    result.field_index   = count_eff;
    result.field_value   = ts_byte ? {{(swpd_pkg::WordWidth - swpd_pkg::ByteWidth){1'b0}},
                                      rx_byte}
                                   : {previous_byte, rx_byte};
    result.field_is_byte = ts_byte;
    result.packet_done   = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_kind0  <= swpd_pkg::SyncKind0Reset;
      sync_kind1  <= swpd_pkg::SyncKind1Reset;
      sync_kind2  <= swpd_pkg::SyncKind2Reset;
      words_kind0 <= swpd_pkg::WordsKind0Reset;
      words_kind1 <= swpd_pkg::WordsKind1Reset;
      words_kind2 <= swpd_pkg::WordsKind2Reset;
    end else if (cfg_we) begin
      case (cfg_index)
        swpd_pkg::CFG_SYNC_KIND0:  sync_kind0  <= cfg_data;
        swpd_pkg::CFG_SYNC_KIND1:  sync_kind1  <= cfg_data;
        swpd_pkg::CFG_SYNC_KIND2:  sync_kind2  <= cfg_data;
        swpd_pkg::CFG_WORDS_KIND0: words_kind0 <= cfg_data[swpd_pkg::WordsWidth-1:0];
        swpd_pkg::CFG_WORDS_KIND1: words_kind1 <= cfg_data[swpd_pkg::WordsWidth-1:0];
        swpd_pkg::CFG_WORDS_KIND2: words_kind2 <= cfg_data[swpd_pkg::WordsWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte <= '0;
      active_kind   <= swpd_pkg::KIND0;
      kind_valid    <= 1'b0;
      field_counter <= '0;
      take_next     <= 1'b0;
    end else if (accept) begin
      previous_byte <= rx_byte;
      active_kind   <= active_kind_next;
      kind_valid    <= kind_valid_next;
      field_counter <= field_counter_next;
      take_next     <= take_next_next;
    end
  end

  // Two-entry result buffer; the skid register only fills on a stalled output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !pop) begin
      if (accept && emit) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_reg <= skid_reg;
      end
    end else if (out_valid && !pop) begin
      if (accept && emit) begin
        skid_reg <= result;
      end
    end else if (accept && emit) begin
      out_reg <= result;
    end
  end

  assign packet_kind   = out_reg.packet_kind;
  assign field_index   = out_reg.field_index;
  assign field_value   = out_reg.field_value;
  assign field_is_byte = out_reg.field_is_byte;
  assign packet_done   = out_reg.packet_done;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_no_result_before_sync: assert property (@(posedge clk) disable iff (rst)
    (accept && !kind_valid && !sync_hit) |-> !emit)
    else $error("result produced before any sync pair");

  a_sync_emits_field0: assert property (@(posedge clk) disable iff (rst)
    (accept && sync_hit) |-> (emit && result.field_index == '0 && !result.field_is_byte))
    else $error("sync pair did not produce the sync word");

  a_sync_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && sync_hit) |=> (kind_valid && field_counter == swpd_pkg::IndexWidth'(1)))
    else $error("counter not advanced after sync word");

  a_done_is_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && packet_done) |-> !field_is_byte)
    else $error("packet end flagged on a byte field");

endmodule

`default_nettype wire
